/* hdl/scroll_offset_stepper_core_assert.svh */
// Assertion macros for the scroll offset stepper core.
`ifndef SCROLL_OFFSET_STEPPER_CORE_ASSERT_SVH
`define SCROLL_OFFSET_STEPPER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clock, off during reset
`define SOS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sos: assertion failed");
// next-cycle implication
`define SOS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sos: assertion failed");
`else
`define SOS_ASSERT_IMP(label, ante, cons)
`define SOS_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* hdl/sos_pkg.sv */
// Shared constants, word types and control structs of the scroll offset stepper.
`timescale 1ns / 1ps
package sos_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int MAX_CATCHUP = 16;
   localparam int TAKEN_W     = $clog2(MAX_CATCHUP + 1);

   localparam logic signed [15:0] UNLIMITED = 16'sd32767;
   localparam logic signed [32:0] ROUND_HALF =
      (FRAC_BITS > 0) ? (33'sd1 <<< (FRAC_BITS - 1)) : 33'sd0;
   localparam logic [31:0] FLOOR_KEEP = ~((32'd1 << FRAC_BITS) - 32'd1);

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_X        = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_Y        = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_INTERVAL = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_COUNT    = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_START_TIME    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_FLAGS    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEWPORT_SIZE = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_CONTENT_RECT  = 4'd7;

   // mode flag bits
   localparam int MODE_SYNC  = 0;
   localparam int MODE_ROUND = 1;
   localparam int MODE_XMAX  = 2;
   localparam int MODE_XMIN  = 3;
   localparam int MODE_YMAX  = 4;
   localparam int MODE_YMIN  = 5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] now_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic [4:0]         steps_taken;
      logic               running;
      logic               completed;
      logic               needs_content;
      logic signed [15:0] remaining_x;
      logic signed [15:0] remaining_y;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic round;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tick_go;
      logic step_ok;
      logic last_step;
   } ctrl_status_type;

endpackage

/* hdl/sos_ctrl.sv */
// Sequencer of the scroll offset stepper: item intake, step loop and result hand-off.
`timescale 1ns / 1ps
module sos_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  sos_pkg::ctrl_status_type status,
   output sos_pkg::ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_STEP   = 3'd2;
   localparam logic [2:0] ST_ROUND  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = status.tick_go ? ST_STEP : ST_ROUND;
         end
         ST_STEP: begin
            if (status.step_ok) begin
               cmd.step = 1'b1;
               if (status.last_step) begin
                  state_in = ST_ROUND;
               end
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/sos_dp.sv */
// Datapath of the scroll offset stepper: registers, scroll state, step and report logic.
`timescale 1ns / 1ps
module sos_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  sos_pkg::req_type                   req_data,
   input  logic                               csr_we,
   input  logic [sos_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                        csr_data,
   input  sos_pkg::ctrl_cmd_type              cmd,
   output sos_pkg::ctrl_status_type           status,
   output sos_pkg::rsp_type                   rsp_data
);

   // one wrap into the content size, positions further out stay out
   function automatic logic [31:0] wrap_axis(
      input logic [31:0]        pos,
      input logic signed [15:0] size,
      input logic               wmax,
      input logic               wmin
   );
      logic [31:0] fs;
      logic [31:0] res;
      fs  = {16'd0, size} << sos_pkg::FRAC_BITS;
      res = pos;
      if (size > 16'sd0) begin
         if (wmax && ($signed({pos[31], pos}) >= $signed({1'b0, fs}))) begin
            res = pos - fs;
         end else if (wmin && pos[31]) begin
            res = pos + fs;
         end
      end
      return res;
   endfunction

   function automatic logic signed [15:0] remaining(
      input logic signed [32:0] rnd,
      input logic signed [15:0] step,
      input logic signed [15:0] cpos,
      input logic signed [15:0] csize,
      input logic [15:0]        vsize,
      input logic               rmax,
      input logic               rmin
   );
      logic signed [35:0] r;
      logic signed [15:0] res;
      r = 36'sd32767;
      if (!rmax && (step > 16'sd0)) begin
         r = 36'(cpos) + 36'(csize) - 36'(rnd) - $signed({20'd0, vsize});
      end
      if (!rmin && (step < 16'sd0)) begin
         r = 36'(rnd) - 36'(cpos);
      end
      if (r > 36'sd32767) begin
         res = sos_pkg::UNLIMITED;
      end else if (r < -36'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = r[15:0];
      end
      return res;
   endfunction

   // configuration
   logic signed [15:0] step_x_ff, step_y_ff;
   logic [31:0]        interval_ff;
   logic signed [24:0] count_ff;
   logic [47:0]        start_ff;
   logic [5:0]         mode_ff;
   logic [31:0]        view_ff;
   logic [63:0]        rect_ff;

   // scroll state
   logic [31:0]        pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [47:0]        nst_ff, nst_in;
   logic signed [24:0] left_ff, left_in;

   // per-item work registers
   logic [1:0]                    kind_ff;
   logic [47:0]                   now_ff;
   logic signed [48:0]            next_ff, next_in;
   logic [sos_pkg::TAKEN_W-1:0]   taken_ff, taken_in;
   logic                          done_ff, done_in;
   logic signed [32:0]            round_x_ff, round_y_ff;
   sos_pkg::rsp_type              rsp_ff;

   logic [47:0]        diff;
   logic [31:0]        sum_x, sum_y;
   logic [7:0]         taken_ext;
   logic signed [15:0] rem_x, rem_y;

   assign diff  = nst_ff - now_ff;
   assign sum_x = pos_x_ff + {{16{step_x_ff[15]}}, step_x_ff};
   assign sum_y = pos_y_ff + {{16{step_y_ff[15]}}, step_y_ff};

   assign status.tick_go   = (kind_ff == sos_pkg::KIND_TICK) && (left_ff != 25'sd0)
                             && (interval_ff != 32'd0);
   assign status.step_ok   = (next_ff[48] || (next_ff == 49'sd0))
                             && (taken_ff < sos_pkg::TAKEN_W'(sos_pkg::MAX_CATCHUP));
   assign status.last_step = (left_ff == 25'sd1);

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      nst_in   = nst_ff;
      left_in  = left_ff;
      next_in  = next_ff;
      taken_in = taken_ff;
      done_in  = done_ff;
      if (cmd.load) begin
         taken_in = '0;
         done_in  = 1'b0;
         next_in  = {diff[47], diff};
         if (kind_ff == sos_pkg::KIND_START) begin
            if (mode_ff[sos_pkg::MODE_ROUND]) begin
               if (step_x_ff != 16'sd0) pos_x_in = pos_x_ff & sos_pkg::FLOOR_KEEP;
               if (step_y_ff != 16'sd0) pos_y_in = pos_y_ff & sos_pkg::FLOOR_KEEP;
            end
            left_in = count_ff;
            nst_in  = ((start_ff == 48'd0) || (start_ff < now_ff)) ? now_ff : start_ff;
         end else if (kind_ff == sos_pkg::KIND_STOP) begin
            left_in = 25'sd0;
         end
      end else if (cmd.step) begin
         taken_in = taken_ff + 1'b1;
         pos_x_in = wrap_axis(sum_x, $signed(rect_ff[47:32]),
                              mode_ff[sos_pkg::MODE_XMAX], mode_ff[sos_pkg::MODE_XMIN]);
         pos_y_in = wrap_axis(sum_y, $signed(rect_ff[63:48]),
                              mode_ff[sos_pkg::MODE_YMAX], mode_ff[sos_pkg::MODE_YMIN]);
         if (left_ff > 25'sd0) begin
            left_in = left_ff - 25'sd1;
         end
         if (status.last_step) begin
            done_in = 1'b1;
         end else if (mode_ff[sos_pkg::MODE_SYNC]) begin
            next_in = next_ff + $signed({17'd0, interval_ff});
            nst_in  = nst_ff + {16'd0, interval_ff};
         end else begin
            next_in = $signed({17'd0, interval_ff});
            nst_in  = now_ff + {16'd0, interval_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff   <= '0;
         step_y_ff   <= '0;
         interval_ff <= '0;
         count_ff    <= -25'sd1;
         start_ff    <= '0;
         mode_ff     <= 6'd1;
         view_ff     <= '0;
         rect_ff     <= '0;
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         nst_ff      <= '0;
         left_ff     <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         nst_ff   <= nst_in;
         left_ff  <= left_in;
         if (csr_we) begin
            unique case (csr_index)
               sos_pkg::REG_STEP_X:        step_x_ff   <= csr_data[15:0];
               sos_pkg::REG_STEP_Y:        step_y_ff   <= csr_data[15:0];
               sos_pkg::REG_STEP_INTERVAL: interval_ff <= csr_data[31:0];
               sos_pkg::REG_STEP_COUNT:    count_ff    <= csr_data[24:0];
               sos_pkg::REG_START_TIME:    start_ff    <= csr_data[47:0];
               sos_pkg::REG_MODE_FLAGS:    mode_ff     <= csr_data[5:0];
               sos_pkg::REG_VIEWPORT_SIZE: view_ff     <= csr_data[31:0];
               sos_pkg::REG_CONTENT_RECT:  rect_ff     <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign taken_ext = 8'(taken_ff);
   assign rem_x = remaining(round_x_ff, step_x_ff, $signed(rect_ff[15:0]),
                            $signed(rect_ff[47:32]), view_ff[15:0],
                            mode_ff[sos_pkg::MODE_XMAX], mode_ff[sos_pkg::MODE_XMIN]);
   assign rem_y = remaining(round_y_ff, step_y_ff, $signed(rect_ff[31:16]),
                            $signed(rect_ff[63:48]), view_ff[31:16],
                            mode_ff[sos_pkg::MODE_YMAX], mode_ff[sos_pkg::MODE_YMIN]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         now_ff  <= req_data.now_time;
      end
      next_ff  <= next_in;
      taken_ff <= taken_in;
      done_ff  <= done_in;
      if (cmd.round) begin
         round_x_ff <= ($signed({pos_x_ff[31], pos_x_ff}) + sos_pkg::ROUND_HALF)
                       >>> sos_pkg::FRAC_BITS;
         round_y_ff <= ($signed({pos_y_ff[31], pos_y_ff}) + sos_pkg::ROUND_HALF)
                       >>> sos_pkg::FRAC_BITS;
      end
      if (cmd.finish) begin
         rsp_ff.offset_x      <= pos_x_ff;
         rsp_ff.offset_y      <= pos_y_ff;
         rsp_ff.steps_taken   <= (taken_ext > 8'd31) ? 5'd31 : taken_ext[4:0];
         rsp_ff.running       <= (left_ff != 25'sd0) && (interval_ff != 32'd0);
         rsp_ff.completed     <= done_ff;
         rsp_ff.needs_content <= rem_x[15] || rem_y[15];
         rsp_ff.remaining_x   <= rem_x;
         rsp_ff.remaining_y   <= rem_y;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/scroll_offset_stepper_core.sv */
// Top level of the scroll offset stepper: sequencer, datapath and assertions.
// Usage:
//  req channel (req_valid/req_stall/req_data) takes one word per item: kind tick,
//   start or stop, plus the current microsecond time. A word is taken when
//   req_valid is high and req_stall is low.
//  rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one word per item:
//   offsets, steps taken, run/complete flags and remaining pixels.
//  csr channel (csr_valid/csr_ready/csr_index/csr_data) writes the registers;
//   csr_ready is always high. Write only while no item is in flight.
// Sequence: start, stop and idle ticks pass through the load, round and finish
//  states. A tick that performs n steps, n at most MAX_CATCHUP, also passes
//  through the step state between load and round; the step loop does one scroll
//  step a cycle through a single add-and-wrap unit per axis.
// Throughput: one item at a time; the next word is taken once the current one
//  has reached the output register.
// Stall: a result waits in the output register while rsp_stall is high; the
//  next item may be taken and worked on meanwhile, and parks before the
//  output register until that is free.
// Reset: synchronous, active high; registers take their reset values, the
//  scroll state clears and the run is stopped.
`timescale 1ns / 1ps
`include "scroll_offset_stepper_core_assert.svh"
module scroll_offset_stepper_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sos_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sos_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sos_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data
);

   sos_pkg::ctrl_cmd_type    cmd;
   sos_pkg::ctrl_status_type status;

   assign csr_ready = 1'b1;

   sos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sos_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

   // an accepted word keeps the intake closed while it is worked on
   `SOS_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // a finished run is no longer running
   `SOS_ASSERT_IMP(a_done_not_running, rsp_valid && rsp_data.completed, !rsp_data.running)
   // completion only comes from a step of this item
   `SOS_ASSERT_IMP(a_done_has_step, rsp_valid && rsp_data.completed, rsp_data.steps_taken != 5'd0)

endmodule
